FILE: src/pfa_pkg.sv
// Shared types and constants of the partition fit allocator.
package pfa_pkg;

  localparam int PARTITIONS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int AMT_W      = 16;
  localparam int IDX_W      = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CMP_W      = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [1:0] REG_PART_CNT  = 2'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef struct packed {
    logic                 vld;
    logic                 found;
    logic [IDX_W-1:0]     pick;
    logic [SIZE_BITS-1:0] left;
    logic [SIZE_BITS-1:0] prev_size;
  } pfa_tok_t;

  typedef struct packed {
    logic active;
    logic we;
  } pfa_cell_ctl_t;

endpackage

FILE: src/pfa_cell.sv
// One partition cell: holds a free size and refines the passing search token.
module pfa_cell
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     my_idx,
  input  pfa_cell_ctl_t        ctl,
  input  logic [SIZE_BITS-1:0] wdata,
  input  logic [1:0]           fit_mode,
  input  logic [AMT_W-1:0]     amount,
  input  pfa_tok_t             tok_in,
  output pfa_tok_t             tok_out
);

  logic [SIZE_BITS-1:0] size_r;
  pfa_tok_t             tok_r;
  pfa_tok_t             tok_nxt;
  logic [CMP_W-1:0]     left_ext;
  logic [SIZE_BITS-1:0] left;
  logic                 fits;
  logic                 take;

  always_comb begin
    left_ext = CMP_W'(size_r) - CMP_W'(amount);
    left     = SIZE_BITS'(left_ext);
    fits     = ctl.active && (CMP_W'(amount) <= CMP_W'(size_r));
    case (fit_mode)
      FIT_FIRST: take = fits && !tok_in.found;
      FIT_BEST:  take = fits && (!tok_in.found || (left < tok_in.left));
      FIT_WORST: take = fits && (!tok_in.found || (left > tok_in.left));
      default:   take = 1'b0;
    endcase
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.pick      = my_idx;
      tok_nxt.left      = left;
      tok_nxt.prev_size = size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      size_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.found     <= tok_nxt.found;
    tok_r.pick      <= tok_nxt.pick;
    tok_r.left      <= tok_nxt.left;
    tok_r.prev_size <= tok_nxt.prev_size;
  end

  assign tok_out = tok_r;

endmodule

FILE: src/partition_fit_allocator_unit.sv
// Top level of the partition fit allocator: a row of partition cells and its control.
// A request walks the cell row one cell per cycle: it is registered in start_r, in each
// cell, in the result register and then in the output register, and the next item is
// taken only once the result is in the output register. A load writes the addressed
// cell's free size and gives no result.
// Synchronous active-low reset clears control, configuration and numbering; the
// free-size table is undefined until loaded.
module partition_fit_allocator_unit
  import pfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // slot_index[3:0], amount[19:4], zero padding
  input  logic        in_tuser,   // req_type
  input  logic        in_tlast,   // last_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // request_number[15:0], granted[16],
                                  // chosen_slot[20:17], size_before[36:21], padding
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [1:0]           fit_mode_r;
  logic [4:0]           part_cnt_r;
  logic                 busy_r;
  logic                 start_r;
  logic [AMT_W-1:0]     amt_r;
  logic [15:0]          cnt_r;
  logic [15:0]          num_r;
  logic                 fin_v_r;
  pfa_tok_t             fin_r;
  logic [15:0]          fin_num_r;
  logic                 out_vld_r;
  logic [39:0]          out_data_r;

  logic [3:0]           in_slot;
  logic [AMT_W-1:0]     in_amt;
  logic                 in_acc;
  logic                 ld_acc;
  logic                 rq_acc;
  logic                 out_free;
  logic                 fin_move;
  pfa_tok_t             tok [0:PARTITIONS];
  pfa_tok_t             tok_end;
  logic                 upd;
  logic [SIZE_BITS-1:0] wdata;

  assign in_slot   = in_tdata[3:0];
  assign in_amt    = in_tdata[19:4];
  assign in_tready = !busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign ld_acc    = in_acc && (in_tuser == REQ_LOAD);
  assign rq_acc    = in_acc && (in_tuser == REQ_ALLOC);
  assign out_free  = !out_vld_r || out_tready;
  assign fin_move  = fin_v_r && out_free;
  assign tok_end   = tok[PARTITIONS];
  assign upd       = tok_end.vld && tok_end.found;
  assign wdata     = ld_acc ? SIZE_BITS'(in_amt) : tok_end.left;

  always_comb begin
    tok[0]        = '0;
    tok[0].vld    = start_r;
  end

  for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
    pfa_cell_ctl_t ctl;
    always_comb begin
      ctl.active = int'(part_cnt_r) > i;
      ctl.we     = (ld_acc && (int'(in_slot) == i)) ||
                   (upd && (tok_end.pick == IDX_W'(i)));
    end
    pfa_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .my_idx   (IDX_W'(i)),
      .ctl      (ctl),
      .wdata    (wdata),
      .fit_mode (fit_mode_r),
      .amount   (amt_r),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= FIT_FIRST;
      part_cnt_r <= '0;
      busy_r     <= 1'b0;
      start_r    <= 1'b0;
      cnt_r      <= '0;
      fin_v_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FIT_MODE: fit_mode_r <= cfg_data[1:0];
          REG_PART_CNT: part_cnt_r <= cfg_data;
          default: ;
        endcase
      end
      start_r <= rq_acc;
      if (rq_acc) begin
        busy_r <= 1'b1;
        cnt_r  <= in_tlast ? 16'd0 : cnt_r + 16'd1;
      end else if (fin_move) begin
        busy_r <= 1'b0;
      end
      if (tok_end.vld) begin
        fin_v_r <= 1'b1;
      end else if (fin_move) begin
        fin_v_r <= 1'b0;
      end
      if (fin_move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_acc) begin
      amt_r <= in_amt;
      num_r <= cnt_r;
    end
    if (tok_end.vld) begin
      fin_r     <= tok_end;
      fin_num_r <= num_r;
    end
    if (fin_move) begin
      out_data_r[15:0]  <= fin_num_r;
      out_data_r[16]    <= fin_r.found;
      out_data_r[20:17] <= fin_r.found ? 4'(fin_r.pick) : 4'd0;
      out_data_r[36:21] <= fin_r.found ? 16'(fin_r.prev_size) : 16'd0;
      out_data_r[39:37] <= 3'd0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vld |-> busy_r)
    else $error("search token left the cell row while idle");
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r |-> busy_r)
    else $error("pending result without a request in flight");
  a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |=> !start_r)
    else $error("two searches started back to back");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !fin_move) |=> !start_r)
    else $error("request accepted while a search was running");
`endif

endmodule
